>>> hdl/salrc_pkg.sv
// Shared constants, result layout and backing-memory contents for the LRU read cache.
package salrc_pkg;

    localparam int BYTE_W     = 8;
    localparam int BLOCK_BITS = 32;
    localparam int CNT_W      = 16;

    // Result word layout, lowest bit first.
    localparam int BYTE_LSB   = 0;
    localparam int HIT_BIT    = 8;
    localparam int EVICT_BIT  = 9;
    localparam int HITS_LSB   = 10;
    localparam int MISSES_LSB = 26;
    localparam int OUT_W      = 48;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // The backing memory holds its own address in every byte, so a block is built
    // from the block-aligned address, most significant byte first.
    function automatic logic [BLOCK_BITS-1:0] fetch_block(input logic [BYTE_W-1:0] addr);
        logic [BYTE_W-1:0] base;
        base = {addr[BYTE_W-1:2], 2'b00};
        return {base, base | 8'h01, base | 8'h02, base | 8'h03};
    endfunction

endpackage

>>> hdl/set_assoc_lru_read_cache.sv
// The block number is split into tag and set with a reciprocal multiply, then the
// set's ways are read once for lookup and once for the LRU update, one way per cycle.
// One request at a time: a new request is taken only once the result has been accepted.
// Reset: i_rst_n is synchronous and active low; afterwards a clearing pass marks every
// line invalid while no request is accepted.
module set_assoc_lru_read_cache #(
    parameter int NUM_SETS  = 4,
    parameter int NUM_WAYS  = 4,
    parameter int ADDR_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // read_address [ADDR_BITS-1:0], zero fill above
    input  logic [((ADDR_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // read_byte [7:0], was_hit [8], did_evict [9], hits_so_far [25:10],
    // misses_so_far [41:26], zero fill [47:42]
    output logic [salrc_pkg::OUT_W-1:0] o_m_axis_tdata
);

    localparam int LINES = NUM_SETS * NUM_WAYS;
    localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int WW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int RW    = WW;
    localparam int SW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int TW    = ADDR_BITS - 2;
    localparam int CW    = $clog2(NUM_WAYS + 1);
    localparam int BW    = salrc_pkg::BLOCK_BITS;
    localparam int CNTW  = salrc_pkg::CNT_W;

    // Reciprocal of NUM_SETS, exact for every block number of TW bits.
    localparam int SHIFT = TW + SW;
    localparam int RCW   = TW + 2;
    localparam int PW    = TW + RCW;
    localparam logic [RCW-1:0] RECIP = RCW'(((1 << SHIFT) + NUM_SETS - 1) / NUM_SETS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;

    typedef struct packed {
        logic          valid;
        logic [RW-1:0] rank;
        logic [TW-1:0] tag;
        logic [BW-1:0] data;
    } t_line;

    // Control state
    logic [2:0]      r_state;
    logic [LW-1:0]   r_clr;
    logic [CW-1:0]   r_cnt;
    logic            r_pv;
    logic            r_ov;
    logic [CNTW-1:0] r_hits;
    logic [CNTW-1:0] r_misses;

    // Request and tag/set split
    logic [ADDR_BITS-1:0] r_addr;
    logic [TW-1:0]        r_blk;
    logic [TW-1:0]        r_q;
    logic [SW-1:0]        r_rem;

    // Line store
    t_line         r_mem [LINES];
    t_line         r_rd;
    logic [WW-1:0] r_pw;

    // Lookup results
    logic          r_hit;
    logic [WW-1:0] r_hw;
    logic [RW-1:0] r_hr;
    logic [BW-1:0] r_data;
    logic          r_inv;
    logic [WW-1:0] r_iw;
    logic [RW-1:0] r_mr;
    logic [WW-1:0] r_mw;

    // Result register
    logic [7:0] r_obyte;
    logic       r_ohit;
    logic       r_oev;

    logic [PW-1:0]   w_prod;
    logic [TW-1:0]   w_quot;
    logic [SW-1:0]   w_qm;
    logic [SW-1:0]   n_rem;
    logic [LW-1:0]   w_base;
    logic            w_issue;
    logic [LW-1:0]   w_rd_addr;
    logic [LW-1:0]   w_wr_addr;
    logic            w_last;
    logic [WW-1:0]   w_victim;
    logic [BW-1:0]   w_fetch;
    logic [BW-1:0]   w_line_data;
    logic [7:0]      w_byte;
    t_line           w_new;
    logic            w_we;
    logic [LW-1:0]   w_wa;
    t_line           w_wd;
    logic            w_accept;
    logic [CNTW-1:0] n_hits;
    logic [CNTW-1:0] n_misses;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Tag = block div NUM_SETS by reciprocal multiply; set = block mod NUM_SETS from the
    // low bits of block - tag*NUM_SETS, in the following cycle.
    assign w_prod = PW'(r_blk) * PW'(RECIP);
    assign w_quot = TW'(w_prod >> SHIFT);
    assign w_qm   = r_q[SW-1:0] * SW'(NUM_SETS);
    assign n_rem  = r_blk[SW-1:0] - w_qm;

    // Line addressing: ways of a set sit next to each other.
    assign w_base    = LW'(r_rem) * LW'(NUM_WAYS);
    assign w_issue   = ((r_state == ST_SCAN) || (r_state == ST_UPD)) && (r_cnt < CW'(NUM_WAYS));
    assign w_rd_addr = w_base + LW'(r_cnt[WW-1:0]);
    assign w_wr_addr = w_base + LW'(r_pw);
    assign w_last    = r_pv && (r_pw == WW'(NUM_WAYS - 1));

    // Way to refill or promote: the hit way, else the first free way, else the oldest.
    assign w_victim = r_hit ? r_hw : (r_inv ? r_iw : r_mw);
    assign w_fetch  = salrc_pkg::fetch_block(r_addr[7:0]);

    // LRU update of one way as it comes back from the store.
    always_comb begin
        w_new = r_rd;
        if (r_pw == w_victim) begin
            w_new.rank = '0;
            if (!r_hit) begin
                w_new.valid = 1'b1;
                w_new.tag   = r_q;
                w_new.data  = w_fetch;
            end
        end else if (r_rd.valid && (!r_hit || (r_rd.rank < r_hr))) begin
            w_new.rank = r_rd.rank + RW'(1);
        end
    end

    // Store write port: the clearing pass or the update pass.
    always_comb begin
        w_we = 1'b0;
        w_wa = w_wr_addr;
        w_wd = w_new;
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_clr;
            w_wd = t_line'('0);
        end else if ((r_state == ST_UPD) && r_pv) begin
            w_we = 1'b1;
        end
    end

    // Byte select, big-endian within the block.
    assign w_line_data = r_hit ? r_data : w_fetch;
    assign w_byte      = w_line_data[{~r_addr[1:0], 3'b000} +: 8];

    assign n_hits   = (r_hits == salrc_pkg::CNT_MAX) ? r_hits : r_hits + CNTW'(1);
    assign n_misses = (r_misses == salrc_pkg::CNT_MAX) ? r_misses : r_misses + CNTW'(1);

    // Line store with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_rd_addr];
        r_pw <= r_cnt[WW-1:0];
    end

    // Sequencer and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
            r_hits   <= '0;
            r_misses <= '0;
        end else begin
            r_pv <= w_issue;
            if (r_ov && i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + LW'(1);
                    if (r_clr == LW'(LINES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_DIV;
                        r_cnt   <= CW'(1);
                    end
                end
                ST_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_SCAN;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                ST_SCAN: begin
                    if (w_issue) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (w_last) begin
                        r_state <= ST_UPD;
                        r_cnt   <= '0;
                    end
                end
                ST_UPD: begin
                    if (w_issue) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (w_last) begin
                        r_state <= ST_IDLE;
                        r_ov    <= 1'b1;
                        if (r_hit) begin
                            r_hits <= n_hits;
                        end else begin
                            r_misses <= n_misses;
                        end
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    // Datapath: request capture, tag and set split, lookup and result.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && w_accept) begin
            r_addr <= i_s_axis_tdata[ADDR_BITS-1:0];
            r_blk  <= i_s_axis_tdata[ADDR_BITS-1:2];
            r_q    <= '0;
            r_rem  <= '0;
        end
        if (r_state == ST_DIV) begin
            if (r_cnt != '0) begin
                r_q <= w_quot;
            end else begin
                r_rem <= n_rem;
                r_hit <= 1'b0;
                r_inv <= 1'b0;
                r_mr  <= '0;
                r_mw  <= '0;
            end
        end
        // Lookup: first matching way, first free way, and the first oldest way.
        if ((r_state == ST_SCAN) && r_pv) begin
            if (!r_hit && r_rd.valid && (r_rd.tag == r_q)) begin
                r_hit  <= 1'b1;
                r_hw   <= r_pw;
                r_hr   <= r_rd.rank;
                r_data <= r_rd.data;
            end
            if (!r_inv && !r_rd.valid) begin
                r_inv <= 1'b1;
                r_iw  <= r_pw;
            end
            if (r_rd.rank > r_mr) begin
                r_mr <= r_rd.rank;
                r_mw <= r_pw;
            end
        end
        if ((r_state == ST_UPD) && w_last) begin
            r_obyte <= w_byte;
            r_ohit  <= r_hit;
            r_oev   <= !r_hit && !r_inv;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_ov;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {6'b000000, r_misses, r_hits, r_oev, r_ohit, r_obyte};

endmodule

>>> hdl/salrc_checker.sv
// Port-level checks for the LRU read cache, bound to its top level.
module salrc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [salrc_pkg::OUT_W-1:0] o_m_axis_tdata
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // No new request is taken while a result waits.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("request accepted with a result pending");

    // An accepted request keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready right after an accepted request");

    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[salrc_pkg::HIT_BIT]
                             && o_m_axis_tdata[salrc_pkg::EVICT_BIT]))
        else $error("hit and evict both set");

    // The total for this kind of access already counts it.
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[salrc_pkg::HIT_BIT]
                ? (o_m_axis_tdata[salrc_pkg::HITS_LSB +: salrc_pkg::CNT_W] != '0)
                : (o_m_axis_tdata[salrc_pkg::MISSES_LSB +: salrc_pkg::CNT_W] != '0)))
        else $error("running total does not include this access");

endmodule

bind set_assoc_lru_read_cache salrc_checker u_salrc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> test/tb.sv
// Self-checking testbench for the four-way LRU read cache with a built-in predictor.
`timescale 1ns / 100ps

module tb;

    localparam int NUM_SETS     = 4;
    localparam int NUM_WAYS     = 4;
    localparam int ADDR_BITS    = 8;
    localparam int LINE_COUNT   = NUM_SETS * NUM_WAYS;
    localparam int RANDOM_READS = 500;
    localparam int MAX_GAP      = 18;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 160;
    localparam int QUIET_FIRST  = 150;
    localparam int QUIET_LAST   = 230;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 200000;

    // One expected result, field by field.
    typedef struct {
        logic [salrc_pkg::BYTE_W-1:0] read_byte;
        logic                         was_hit;
        logic                         did_evict;
        logic [salrc_pkg::CNT_W-1:0]  hits_so_far;
        logic [salrc_pkg::CNT_W-1:0]  misses_so_far;
    } t_read_result;

    // Cache predictor plus the queue of results still owed by the block.
    class cache_scoreboard;
        logic                        line_valid [LINE_COUNT];
        logic [3:0]                  line_tag   [LINE_COUNT];
        logic [31:0]                 line_block [LINE_COUNT];
        logic [7:0]                  line_age   [LINE_COUNT];
        logic [7:0]                  backing    [256];
        logic [salrc_pkg::CNT_W-1:0] hit_tally;
        logic [salrc_pkg::CNT_W-1:0] miss_tally;
        t_read_result                expected_reads [$];
        int                          fail_count;
        int                          checked;
        int                          hits_seen;
        int                          evicts_seen;

        function new();
            for (int i = 0; i < LINE_COUNT; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_block[i] = '0;
                line_age[i]   = '0;
            end
            for (int i = 0; i < 256; i++) begin
                backing[i] = i[7:0];
            end
            hit_tally   = '0;
            miss_tally  = '0;
            fail_count  = 0;
            checked     = 0;
            hits_seen   = 0;
            evicts_seen = 0;
        endfunction

        function int pending();
            return expected_reads.size();
        endfunction

        task report(string what);
            $display("tb: mismatch: %s", what);
            fail_count++;
        endtask

        // Applies one accepted read request to the predicted cache state.
        function void note_read(logic [7:0] addr);
            int           base;
            int           line;
            int           idx;
            logic         hit;
            logic         evict;
            logic         found;
            logic [7:0]   rank;
            logic [7:0]   best;
            logic [3:0]   tag;
            logic [7:0]   block_base;
            t_read_result res;

            base  = int'(addr[3:2]) * NUM_WAYS;
            tag   = addr[7:4];
            hit   = 1'b0;
            evict = 1'b0;
            line  = base;

            for (int w = 0; w < NUM_WAYS; w++) begin
                if (!hit && line_valid[base + w] && line_tag[base + w] == tag) begin
                    hit  = 1'b1;
                    line = base + w;
                end
            end

            if (hit) begin
                // Ways newer than the hit way age by one; the hit way becomes newest.
                rank = line_age[line];
                for (int w = 0; w < NUM_WAYS; w++) begin
                    idx = base + w;
                    if (line_valid[idx] && idx != line && line_age[idx] < rank)
                        line_age[idx]++;
                end
                line_age[line] = '0;
                if (hit_tally != salrc_pkg::CNT_MAX) hit_tally++;
            end else begin
                // Take the lowest free way, or else the oldest way of a full set.
                found = 1'b0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (!found && !line_valid[base + w]) begin
                        line  = base + w;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    best = '0;
                    line = base;
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        if (line_age[base + w] > best) begin
                            best = line_age[base + w];
                            line = base + w;
                        end
                    end
                    evict = 1'b1;
                end
                for (int w = 0; w < NUM_WAYS; w++) begin
                    idx = base + w;
                    if (line_valid[idx] && idx != line && line_age[idx] < 8'hFF)
                        line_age[idx]++;
                end
                // Fill big-endian: the lowest address lands in the top byte.
                block_base = {addr[7:2], 2'b00};
                for (int b = 0; b < 4; b++) begin
                    line_block[line][31 - 8*b -: 8] = backing[block_base + b[7:0]];
                end
                line_valid[line] = 1'b1;
                line_tag[line]   = tag;
                line_age[line]   = '0;
                if (miss_tally != salrc_pkg::CNT_MAX) miss_tally++;
            end

            res.read_byte     = line_block[line][31 - 8*int'(addr[1:0]) -: 8];
            res.was_hit       = hit;
            res.did_evict     = evict;
            res.hits_so_far   = hit_tally;
            res.misses_so_far = miss_tally;
            expected_reads.push_back(res);
        endfunction

        // Compares one result word from the block against the oldest expectation.
        task check_result(logic [salrc_pkg::OUT_W-1:0] word);
            t_read_result                 exp_res;
            logic [salrc_pkg::BYTE_W-1:0] got_byte;
            logic [salrc_pkg::CNT_W-1:0]  got_hits;
            logic [salrc_pkg::CNT_W-1:0]  got_misses;

            got_byte   = word[salrc_pkg::BYTE_LSB +: salrc_pkg::BYTE_W];
            got_hits   = word[salrc_pkg::HITS_LSB +: salrc_pkg::CNT_W];
            got_misses = word[salrc_pkg::MISSES_LSB +: salrc_pkg::CNT_W];
            if (expected_reads.size() == 0) begin
                report($sformatf("result %h with no read outstanding", word));
                return;
            end
            exp_res = expected_reads.pop_front();
            checked++;
            if (exp_res.was_hit) hits_seen++;
            if (exp_res.did_evict) evicts_seen++;
            if (got_byte !== exp_res.read_byte)
                report($sformatf("read %0d: byte %h, expected %h",
                                 checked, got_byte, exp_res.read_byte));
            if (word[salrc_pkg::HIT_BIT] !== exp_res.was_hit)
                report($sformatf("read %0d: hit flag %b, expected %b",
                                 checked, word[salrc_pkg::HIT_BIT], exp_res.was_hit));
            if (word[salrc_pkg::EVICT_BIT] !== exp_res.did_evict)
                report($sformatf("read %0d: evict flag %b, expected %b",
                                 checked, word[salrc_pkg::EVICT_BIT], exp_res.did_evict));
            if (got_hits !== exp_res.hits_so_far)
                report($sformatf("read %0d: hit total %0d, expected %0d",
                                 checked, got_hits, exp_res.hits_so_far));
            if (got_misses !== exp_res.misses_so_far)
                report($sformatf("read %0d: miss total %0d, expected %0d",
                                 checked, got_misses, exp_res.misses_so_far));
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic [7:0]                  s_tdata = '0;
    logic                        m_tready = 1'b0;
    logic                        o_s_axis_tready;
    logic                        o_m_axis_tvalid;
    logic [salrc_pkg::OUT_W-1:0] o_m_axis_tdata;

    cache_scoreboard   book = new();
    logic              quiet_phase = 1'b0;
    int                cycle_count = 0;
    int                results_taken = 0;
    logic [7:0]        last_addr = '0;
    int                focus_set = 0;

    set_assoc_lru_read_cache #(
        .NUM_SETS  (NUM_SETS),
        .NUM_WAYS  (NUM_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),          // read_address [7:0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)    // byte, hit, evict, hits, misses
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Offers one read request and waits until the block takes it.
    task automatic issue_read(input logic [7:0] addr);
        int gap;

        gap = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        book.note_read(addr);
        last_addr = addr;
    endtask

    // Random addresses, mostly from a small pool of tags so that sets fill,
    // hit and evict; the rest revisits the last block or is fully random.
    function automatic logic [7:0] pick_address();
        int mode;
        logic [7:0] addr;

        mode = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0) focus_set = $urandom_range(0, NUM_SETS - 1);
        if (mode < 55) begin
            addr[7:4] = 4'($urandom_range(0, 5));
            addr[3:2] = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3))
                                                     : 2'(focus_set);
            addr[1:0] = 2'($urandom_range(0, 3));
        end else if (mode < 70) begin
            addr = {last_addr[7:2], 2'($urandom_range(0, 3))};
        end else begin
            addr = 8'($urandom_range(0, 255));
        end
        return addr;
    endfunction

    // Receiving side: random stalls once a result is up, plus one long hold.
    initial begin
        int stall;

        wait (i_rst_n === 1'b1);
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
            if (results_taken == HOLD_AT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_tready <= 1'b0;
                do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
                repeat (stall - 1) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            book.check_result(o_m_axis_tdata);
            results_taken++;
        end
    end

    // Main sequence: reset, directed reads, random reads, drain.
    initial begin
        logic [7:0] directed [];

        directed = '{
            8'h00, 8'h00, 8'h03, 8'hFF, 8'hFC, 8'h10, 8'h21, 8'h32,
            8'h12, 8'h40, 8'h02, 8'h51, 8'h43, 8'h23, 8'h60, 8'h13,
            8'hAA, 8'h55, 8'hFE, 8'h01, 8'hF3, 8'h7C
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Cold miss, hits on byte offsets 0, 2 and 3, a full set, a hit in the middle of
        // the recency order, and evictions of the oldest way.
        foreach (directed[i]) issue_read(directed[i]);

        for (int n = 0; n < RANDOM_READS; n++) begin
            quiet_phase = (n >= QUIET_FIRST && n < QUIET_LAST);
            issue_read(pick_address());
        end
        quiet_phase = 1'b0;
        s_tvalid <= 1'b0;

        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d reads checked: %0d hits, %0d evictions, one %0d-cycle output hold",
                 book.checked, book.hits_seen, book.evicts_seen, HOLD_CYCLES);
        if (book.fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> set_assoc_lru_read_cache.f
hdl/salrc_pkg.sv
hdl/set_assoc_lru_read_cache.sv
hdl/salrc_checker.sv
test/tb.sv
